// File: design/lspq_pkg.sv
package lspq_pkg;

  // Queue geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int FILL_W = 5;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [ADDR_W-1:0] CAP_ADDR  = ADDR_W'(0);

  // Commands
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] prio;
  } entry_t;

  // Capacity clipped to the physical depth, widened for compare against count
  function automatic logic [CMP_W-1:0] usable_cap(input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] c;
    c = CMP_W'(cap);
    return (c > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : c;
  endfunction

endpackage

// File: design/linear_scan_priority_queue.sv
// Priority queue kept as an unsorted array in arrival order.
// Input channel (in_valid/in_ready): command (0 enqueue, 1 dequeue), data_in,
// priority_in. Output channel (out_valid/out_ready): one result per input
// transaction: status (0 done, 1 full, 2 empty), removed_data,
// removed_priority (zero unless a dequeue succeeded) and fill_count.
// APB port: register 0 at byte address 0 is capacity (reset 16, values above
// the depth act as the depth).
// An enqueue or a refused operation goes from accept through ST_RESP into
// the output register, and the next item can be taken once the sequencer
// is back in ST_IDLE. A dequeue on n held entries whose winner sits at
// place b reads all n entries, one memory read per cycle
// through a single signed comparator, to find the winner, then the same read
// port plus the write port move the later entries down one place per cycle.
// One item is worked on at a time; in_ready is high only while the sequencer
// is idle. The result register lets a new item be accepted while a finished
// result still waits; if the receiver stalls, the next result is held
// inside until the output register frees up.
// Reset empties the queue (count zero) and sets capacity to 16; the entry
// memory is not cleared since only written entries are ever read.
module linear_scan_priority_queue
  import lspq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic signed [DATA_W-1:0] data_in,
  input  logic signed [DATA_W-1:0] priority_in,
  // output channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic signed [DATA_W-1:0] removed_data,
  output logic signed [DATA_W-1:0] removed_priority,
  output logic [FILL_W-1:0]      fill_count,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  state_t state, state_next;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic             pend, pend_next;
  logic [IDX_W-1:0] pidx, pidx_next;
  logic [IDX_W-1:0] best_idx, best_idx_next;
  logic             best_vld, best_vld_next;
  entry_t           best, best_next;
  status_t          res_status, res_status_next;
  status_t          out_status, out_status_next;
  logic [DATA_W-1:0] out_data, out_data_next;
  logic [DATA_W-1:0] out_prio, out_prio_next;
  logic [FILL_W-1:0] out_fill, out_fill_next;
  logic             out_vld, out_vld_next;

  // entry memory: one write port, one registered read port
  entry_t           mem [DEPTH];
  entry_t           rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic accept;
  logic take;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  // APB register file
  assign pready = 1'b1;
  assign prdata = (paddr == CAP_ADDR) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // shared signed comparator: strict, so the earliest entry wins ties
  assign take = pend && (!best_vld || ($signed(rd_q.prio) > $signed(best.prio)));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      pend    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      pend    <= pend_next;
      out_vld <= out_vld_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    pidx       <= pidx_next;
    best_idx   <= best_idx_next;
    best_vld   <= best_vld_next;
    best       <= best_next;
    res_status <= res_status_next;
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_prio   <= out_prio_next;
    out_fill   <= out_fill_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    count_next      = count;
    ptr_next        = ptr;
    pend_next       = 1'b0;
    pidx_next       = pidx;
    best_idx_next   = best_idx;
    best_vld_next   = best_vld;
    best_next       = best;
    res_status_next = res_status;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_prio_next   = out_prio;
    out_fill_next   = out_fill;
    out_vld_next    = out_vld && !out_ready;
    rd_addr         = ptr[IDX_W-1:0];
    rd_issue        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = count[IDX_W-1:0];
    wr_data         = '{data: data_in, prio: priority_in};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          best_next     = '0;
          best_vld_next = 1'b0;
          ptr_next      = '0;
          if (command == CMD_ENQ) begin
            if (CMP_W'(count) >= usable_cap(capacity)) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_en           = 1'b1;
              count_next      = count + CNT_W'(1);
              res_status_next = STAT_DONE;
            end
            state_next = ST_RESP;
          end else if (count == '0) begin
            res_status_next = STAT_EMPTY;
            state_next      = ST_RESP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the entry read last cycle
        if (ptr < count) begin
          rd_issue  = 1'b1;
          rd_addr   = ptr[IDX_W-1:0];
          ptr_next  = ptr + CNT_W'(1);
          pend_next = 1'b1;
          pidx_next = ptr[IDX_W-1:0];
        end
        if (take) begin
          best_next     = rd_q;
          best_idx_next = pidx;
          best_vld_next = 1'b1;
        end
        if (ptr >= count && pend) begin
          ptr_next   = CNT_W'(take ? pidx : best_idx) + CNT_W'(1);
          pend_next  = 1'b0;
          state_next = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // read entry i+1, write it to place i on the next cycle
        if (ptr < count) begin
          rd_issue  = 1'b1;
          rd_addr   = ptr[IDX_W-1:0];
          ptr_next  = ptr + CNT_W'(1);
          pend_next = 1'b1;
          pidx_next = ptr[IDX_W-1:0];
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pidx - IDX_W'(1);
          wr_data = rd_q;
        end
        if (ptr >= count && !pend) begin
          count_next      = count - CNT_W'(1);
          res_status_next = STAT_DONE;
          state_next      = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_vld || out_ready) begin
          out_vld_next    = 1'b1;
          out_status_next = res_status;
          out_data_next   = best.data;
          out_prio_next   = best.prio;
          out_fill_next   = FILL_W'(count);
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid        = out_vld;
  assign status           = out_status;
  assign removed_data     = out_data;
  assign removed_priority = out_prio;
  assign fill_count       = out_fill;

`ifndef SYNTHESIS
  // a dequeue on a nonempty queue starts the scan
  a_deq_scan: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_DEQ && count != '0 |=> state == ST_SCAN)
    else $error("dequeue did not start scan");

  // count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |->
      (count == $past(count) + CNT_W'(1) || count + CNT_W'(1) == $past(count)))
    else $error("count jumped");

  // reads stay below the fill count
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    rd_issue |-> ptr < count)
    else $error("read beyond held entries");

  // every pending shift read is written back
  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT && pend |-> wr_en)
    else $error("shift dropped an entry");

  // count never exceeds the depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("count above depth");
`endif

endmodule
